// ===== sv/arsh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsh_pkg
// Shared types and constants of the address range sample histogram.
// ----------------------------------------------------------------------------
package arsh_pkg;

	localparam int TABLE_DEPTH  = 16384;
	localparam int MAX_BINS     = 1000;
	localparam int SAMPLE_LIMIT = 500000;
	localparam int TOP_N        = 5;
	localparam int MAX_OUT      = 5;
	localparam int N_OUT        = (TOP_N < MAX_OUT) ? TOP_N : MAX_OUT;

	localparam int ADDR_W = 64;
	localparam int AW     = $clog2(TABLE_DEPTH);
	localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W  = SIZE_W;
	localparam int CNT_W  = 19;
	localparam int BIN_W  = 11;
	localparam int IDX_W  = 14;
	localparam int RANK_W = 3;
	localparam int SEL_W  = (N_OUT > 1) ? $clog2(N_OUT) : 1;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_LOAD   = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_REPORT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_RANKED = 2'd0,
		ST_NONE   = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RD0,
		S_CHK0,
		S_MID,
		S_CMP,
		S_CNT_RD,
		S_CNT_WR,
		S_SCAN0,
		S_SCAN,
		S_EMIT,
		S_ONE
	} state_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [ADDR_W-1:0] symbol_start;
		logic [ADDR_W-1:0] sample_address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [RANK_W-1:0] rank;
		logic [IDX_W-1:0]  symbol_index;
		logic              is_unknown;
		logic [CNT_W-1:0]  bin_count;
		logic [CNT_W-1:0]  total_samples;
		logic              last;
	} rsp_t;

	// One slot of the running top list.
	typedef struct packed {
		logic             vld;
		logic [CNT_W-1:0] cnt;
		logic [KEY_W-1:0] key;
	} ent_t;

endpackage
`default_nettype wire

// ===== sv/arsh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsh_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module arsh_ram #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/arsh_top5.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsh_top5
// Running sorted list of the largest bins, one candidate inserted per cycle.
// ----------------------------------------------------------------------------
module arsh_top5 import arsh_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   clr,
	input  wire logic                   offer,
	input  wire logic [CNT_W-1:0]       ocnt,
	input  wire logic [KEY_W-1:0]       okey,
	output ent_t      [N_OUT-1:0]       list
);

	ent_t [N_OUT-1:0] list_q;
	ent_t [N_OUT-1:0] list_d;
	logic [N_OUT-1:0] gt;
	ent_t             cand;

	// Keys arrive in ascending order, so a tie stays behind the older entry.
	always_comb begin
		cand = '{vld: 1'b1, cnt: ocnt, key: okey};
		for (int i = 0; i < N_OUT; i++) begin
			gt[i] = !list_q[i].vld || (ocnt > list_q[i].cnt);
		end
		for (int i = 0; i < N_OUT; i++) begin
			if (!gt[i]) begin
				list_d[i] = list_q[i];
			end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
				list_d[i] = list_q[(i > 0) ? i - 1 : 0];
			end else begin
				list_d[i] = cand;
			end
		end
	end

	// List register; empty bins are never entered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_q <= '0;
		end else if (clr) begin
			list_q <= '0;
		end else if (offer && ocnt != '0) begin
			list_q <= list_d;
		end
	end

	assign list = list_q;

endmodule
`default_nettype wire

// ===== sv/address_range_sample_histogram_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// address_range_sample_histogram_top
// Symbol table lookup by binary search and per-symbol sample histogram.
// ----------------------------------------------------------------------------
// One beat is handled at a time under a small sequencer around two RAM ports.
// After reset and after every start beat a clearing pass over all 16384
// entries zeroes the count memory; no request beat is taken meanwhile. A
// rejected load answers with a status beat and waits while the output stalls.
// A sample walks the address table one read per step and then does a
// read-modify-write of its count. A report scans every table entry once
// through the count RAM read port and then sends up to five result beats.
// ----------------------------------------------------------------------------
module address_range_sample_histogram_top import arsh_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	state_t state_q, state_d;

	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] last_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIZE_W-1:0] lo_q, hi_q, mid_q;
	logic              unk_q;
	logic [CNT_W-1:0]  unk_cnt_q;
	logic [CNT_W-1:0]  acc_q;
	logic [BIN_W-1:0]  bins_q;
	logic [AW-1:0]     clr_q;
	logic [SIZE_W-1:0] ridx_q;
	logic              pend_q;
	logic [KEY_W-1:0]  pkey_q;
	logic [SEL_W-1:0]  n_q;
	rsp_t              one_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              take;
	logic              can_emit;
	logic              load_bad;
	logic [SIZE_W-1:0] mid;
	logic [ADDR_W-1:0] a_rdata;
	logic [CNT_W-1:0]  c_rdata;
	logic              c_we;
	logic [AW-1:0]     c_waddr, c_raddr;
	logic [CNT_W-1:0]  c_wdata;
	logic [AW-1:0]     a_raddr;
	logic [CNT_W-1:0]  cur_cnt;
	logic              bump;
	logic              t_clr, t_offer;
	logic [CNT_W-1:0]  t_cnt;
	logic [KEY_W-1:0]  t_key;
	ent_t [N_OUT-1:0]  list;
	logic [N_OUT-1:0]  vld_nxt;
	ent_t              sel;
	logic              emit_last;
	rsp_t              emit_rsp;

	assign take     = req_valid && !req_stall;
	assign can_emit = !rsp_valid_q || !rsp_stall;
	assign load_bad = (size_q >= SIZE_W'(TABLE_DEPTH)) ||
		(size_q != '0 && req.symbol_start <= last_q);
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign cur_cnt  = unk_q ? unk_cnt_q : c_rdata;
	assign bump     = !(cur_cnt == '0 && bins_q >= BIN_W'(MAX_BINS));
	assign req_stall = (state_q != S_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == AW'(TABLE_DEPTH - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (take) begin
					unique case (op_t'(req.operation))
						OP_START:  state_d = S_CLEAR;
						OP_LOAD:   if (load_bad) state_d = S_ONE;
						OP_SAMPLE: begin
							if (acc_q < CNT_W'(SAMPLE_LIMIT)) begin
								state_d = (size_q == '0) ? S_CNT_RD : S_RD0;
							end
						end
						OP_REPORT: state_d = (acc_q == '0) ? S_ONE : S_SCAN0;
					endcase
				end
			end
			S_RD0:    state_d = S_CHK0;
			S_CHK0:   state_d = (addr_q < a_rdata) ? S_CNT_RD : S_MID;
			S_MID:    state_d = (hi_q - lo_q > SIZE_W'(1)) ? S_CMP : S_CNT_RD;
			S_CMP:    state_d = S_MID;
			S_CNT_RD: state_d = S_CNT_WR;
			S_CNT_WR: state_d = S_IDLE;
			S_SCAN0:  state_d = S_SCAN;
			S_SCAN:   if (!pend_q && ridx_q >= size_q) state_d = S_EMIT;
			S_EMIT:   if (can_emit && emit_last) state_d = S_IDLE;
			S_ONE:    if (can_emit) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// RAM port and top list controls.
	always_comb begin
		c_we    = 1'b0;
		c_waddr = lo_q[AW-1:0];
		c_wdata = c_rdata + CNT_W'(1);
		c_raddr = lo_q[AW-1:0];
		a_raddr = mid[AW-1:0];
		t_clr   = 1'b0;
		t_offer = 1'b0;
		t_cnt   = c_rdata;
		t_key   = pkey_q;
		unique case (state_q)
			S_CLEAR: begin
				c_we    = 1'b1;
				c_waddr = clr_q;
				c_wdata = '0;
			end
			S_IDLE:   t_clr = take;
			S_RD0:    a_raddr = '0;
			S_CNT_WR: c_we = bump && !unk_q;
			S_SCAN0: begin
				t_offer = 1'b1;
				t_cnt   = unk_cnt_q;
				t_key   = '0;
			end
			S_SCAN: begin
				t_offer = pend_q;
				c_raddr = ridx_q[AW-1:0];
			end
			default: ;
		endcase
	end

	// Ranked result built from the top list slot under the emit counter.
	always_comb begin
		vld_nxt = '0;
		for (int i = 0; i + 1 < N_OUT; i++) begin
			vld_nxt[i] = list[i + 1].vld;
		end
		sel       = list[n_q];
		emit_last = (n_q == SEL_W'(N_OUT - 1)) || !vld_nxt[n_q];
		emit_rsp  = '0;
		emit_rsp.status        = ST_RANKED;
		emit_rsp.rank          = RANK_W'(n_q);
		emit_rsp.is_unknown    = (sel.key == '0);
		emit_rsp.symbol_index  = (sel.key == '0) ? '0 : IDX_W'(sel.key - KEY_W'(1));
		emit_rsp.bin_count     = sel.cnt;
		emit_rsp.total_samples = acc_q;
		emit_rsp.last          = emit_last;
	end

	// Sequencer and bookkeeping registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			size_q    <= '0;
			unk_cnt_q <= '0;
			acc_q     <= '0;
			bins_q    <= '0;
			clr_q     <= '0;
			pend_q    <= 1'b0;
			n_q       <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_CLEAR: clr_q <= clr_q + AW'(1);
				S_IDLE: begin
					if (take) begin
						unique case (op_t'(req.operation))
							OP_START: begin
								unk_cnt_q <= '0;
								acc_q     <= '0;
								bins_q    <= '0;
								clr_q     <= '0;
							end
							OP_LOAD: if (!load_bad) size_q <= size_q + SIZE_W'(1);
							OP_SAMPLE: begin
								if (acc_q < CNT_W'(SAMPLE_LIMIT)) acc_q <= acc_q + CNT_W'(1);
							end
							OP_REPORT: n_q <= '0;
						endcase
					end
				end
				S_CNT_WR: begin
					if (bump) begin
						if (cur_cnt == '0) bins_q <= bins_q + BIN_W'(1);
						if (unk_q) unk_cnt_q <= unk_cnt_q + CNT_W'(1);
					end
				end
				S_SCAN0: pend_q <= 1'b0;
				S_SCAN:  pend_q <= (ridx_q < size_q);
				S_EMIT:  if (can_emit) n_q <= n_q + SEL_W'(1);
				default: ;
			endcase
		end
	end

	// Search and scan datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				addr_q <= req.sample_address;
				unk_q  <= (size_q == '0);
				lo_q   <= '0;
				hi_q   <= size_q;
				one_q  <= '{
					status:        (op_t'(req.operation) == OP_LOAD) ? ST_REJECT : ST_NONE,
					rank:          '0,
					symbol_index:  '0,
					is_unknown:    1'b0,
					bin_count:     '0,
					total_samples: '0,
					last:          1'b1
				};
				if (take && op_t'(req.operation) == OP_LOAD && !load_bad) begin
					last_q <= req.symbol_start;
				end
			end
			S_CHK0: unk_q <= (addr_q < a_rdata);
			S_MID:  mid_q <= mid;
			S_CMP: begin
				if (a_rdata <= addr_q) lo_q <= mid_q;
				else                   hi_q <= mid_q;
			end
			S_SCAN0: ridx_q <= '0;
			S_SCAN: begin
				if (ridx_q < size_q) begin
					ridx_q <= ridx_q + SIZE_W'(1);
					pkey_q <= KEY_W'(ridx_q + SIZE_W'(1));
				end
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (can_emit) begin
			rsp_valid_q <= (state_q == S_EMIT) || (state_q == S_ONE);
		end
	end

	always_ff @(posedge clk) begin
		if (can_emit) begin
			rsp_q <= (state_q == S_ONE) ? one_q : emit_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Symbol start addresses.
	arsh_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ADDR_W)) u_addr_ram (
		.clk   (clk),
		.we    (take && op_t'(req.operation) == OP_LOAD && !load_bad),
		.waddr (size_q[AW-1:0]),
		.wdata (req.symbol_start),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	// Per-symbol sample counts.
	arsh_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(CNT_W)) u_cnt_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// Largest bins seen during a report scan.
	arsh_top5 u_top5 (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (t_clr),
		.offer  (t_offer),
		.ocnt   (t_cnt),
		.okey   (t_key),
		.list   (list)
	);

endmodule
`default_nettype wire

// ===== sv/arsh_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsh_checker
// Port-level checks of the histogram result stream.
// ----------------------------------------------------------------------------
module arsh_checker import arsh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// A stalled result beat stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result beat dropped while stalled");

	// Status beats are single and final.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_REJECT || rsp.status == ST_NONE) |-> rsp.last)
		else $error("status beat not marked last");

	// A no-samples beat reports an empty total.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_NONE |-> rsp.total_samples == '0)
		else $error("no-samples beat with nonzero total");

	// A ranked bin is nonempty and within the total.
	a_ranked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_RANKED |->
		rsp.bin_count != '0 && rsp.bin_count <= rsp.total_samples &&
		rsp.rank < RANK_W'(N_OUT))
		else $error("ranked beat out of range");

endmodule

bind address_range_sample_histogram_top arsh_checker u_chk (.*);
`default_nettype wire

// ===== bench/address_range_sample_histogram_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_sample_histogram_top_test
// Self-checking bench for the address range sample histogram. A directed
// opening covers empty tables, rejected loads, the unknown bin and empty
// reports. A random phase follows with bursty requests and a stalling
// receiver.
// ----------------------------------------------------------------------------
module address_range_sample_histogram_top_test;
	import arsh_pkg::*;

	// Tracks the histogram state and the queue of result beats still due.
	class histogram_scoreboard;
		logic [63:0] table_addr[TABLE_DEPTH];
		int          entries;
		int          entry_hits[TABLE_DEPTH];
		int          unknown_hits;
		int          total_taken;
		int          bins_used;
		rsp_t        due_results[$];
		int          errors;

		function new();
			entries = 0;
			unknown_hits = 0;
			total_taken = 0;
			bins_used = 0;
			errors = 0;
			foreach (entry_hits[i]) entry_hits[i] = 0;
		endfunction

		function void push_result(logic [1:0] st, int rank, int idx, bit unk,
				int cnt, int tot, bit lst);
			rsp_t r;
			r.status = st;
			r.rank = rank[RANK_W-1:0];
			r.symbol_index = idx[IDX_W-1:0];
			r.is_unknown = unk;
			r.bin_count = cnt[CNT_W-1:0];
			r.total_samples = tot[CNT_W-1:0];
			r.last = lst;
			due_results.push_back(r);
		endfunction

		// Last entry at or below the address; -1 for the unknown bin.
		function int lookup_bin(logic [63:0] addr);
			int lo;
			int hi;
			int mid;
			if (entries == 0 || addr < table_addr[0]) return -1;
			lo = 0;
			hi = entries;
			while (hi - lo > 1) begin
				mid = lo + (hi - lo) / 2;
				if (table_addr[mid] <= addr) lo = mid;
				else hi = mid;
			end
			return lo;
		endfunction

		function int hits_of(int key);
			return (key == 0) ? unknown_hits : entry_hits[key - 1];
		endfunction

		function void rank_bins();
			int prev_cnt;
			int prev_key;
			bit have_prev;
			int n;
			int best_cnt;
			int best_key;
			bit found;
			int c;
			if (total_taken == 0) begin
				push_result(ST_NONE, 0, 0, 0, 0, 0, 1);
				return;
			end
			have_prev = 0;
			prev_cnt = 0;
			prev_key = 0;
			n = 0;
			while (n < N_OUT) begin
				found = 0;
				best_cnt = 0;
				best_key = 0;
				for (int key = 0; key <= entries; key++) begin
					c = hits_of(key);
					if (c == 0) continue;
					if (have_prev && !(c < prev_cnt || (c == prev_cnt && key > prev_key)))
						continue;
					if (!found || c > best_cnt) begin
						found = 1;
						best_cnt = c;
						best_key = key;
					end
				end
				if (!found) break;
				push_result(ST_RANKED, n, (best_key == 0) ? 0 : best_key - 1,
					best_key == 0, best_cnt, total_taken, 0);
				n++;
				have_prev = 1;
				prev_cnt = best_cnt;
				prev_key = best_key;
			end
			due_results[$].last = 1;
		endfunction

		// Applies one accepted request beat to the expected state.
		function void note_request(req_t r);
			int b;
			case (op_t'(r.operation))
				OP_START: begin
					foreach (entry_hits[i]) entry_hits[i] = 0;
					unknown_hits = 0;
					total_taken = 0;
					bins_used = 0;
				end
				OP_LOAD: begin
					if (entries >= TABLE_DEPTH ||
							(entries > 0 && r.symbol_start <= table_addr[entries - 1]))
						push_result(ST_REJECT, 0, 0, 0, 0, 0, 1);
					else begin
						table_addr[entries] = r.symbol_start;
						entries++;
					end
				end
				OP_SAMPLE: begin
					if (total_taken < SAMPLE_LIMIT) begin
						total_taken++;
						b = lookup_bin(r.sample_address);
						if (hits_of(b + 1) != 0 || bins_used < MAX_BINS) begin
							if (hits_of(b + 1) == 0) bins_used++;
							if (b < 0) unknown_hits++;
							else entry_hits[b]++;
						end
					end
				end
				default: rank_bins();
			endcase
		endfunction

		// Compares one result beat with the oldest one due.
		function void check_result(rsp_t got);
			rsp_t want;
			if (due_results.size() == 0) begin
				$error("unexpected result beat %p", got);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.rank !== want.rank) begin
				$error("rank: expected %0d, got %0d", want.rank, got.rank);
				errors++;
			end
			if (got.symbol_index !== want.symbol_index) begin
				$error("symbol_index: expected %0d, got %0d", want.symbol_index,
					got.symbol_index);
				errors++;
			end
			if (got.is_unknown !== want.is_unknown) begin
				$error("is_unknown: expected %0d, got %0d", want.is_unknown, got.is_unknown);
				errors++;
			end
			if (got.bin_count !== want.bin_count) begin
				$error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
				errors++;
			end
			if (got.total_samples !== want.total_samples) begin
				$error("total_samples: expected %0d, got %0d", want.total_samples,
					got.total_samples);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	histogram_scoreboard sb;
	int burst_left;
	int stall_mode;
	int stall_span;

	address_range_sample_histogram_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Overall time limit.
	initial begin
		#36000000;
		$display("Some tests failed");
		$finish;
	end

	// Result beats are checked at every accepting edge.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_result(rsp);
	end

	// The receiver switches between no stall, light stall and heavy stall.
	always @(negedge clk) begin
		if (stall_span <= 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_span = $urandom_range(50, 400);
		end
		stall_span--;
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			default: rsp_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Sends one beat and waits for it to be taken; bursts end in random gaps.
	task automatic send_beat(input op_t op, input logic [63:0] sym,
			input logic [63:0] addr);
		req_t r;
		int gap;
		r.operation = op;
		r.symbol_start = sym;
		r.sample_address = addr;
		@(negedge clk);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Picks a sample address that exercises lookups across the table.
	function automatic logic [63:0] pick_sample_address();
		int idx;
		int mode;
		logic [63:0] base;
		logic [63:0] span;
		mode = $urandom_range(0, 9);
		if (sb.entries == 0 || mode == 0) return rand_word();
		if (mode == 1) begin
			base = sb.table_addr[0];
			return (base == 0) ? 64'd0 : rand_word() % base;
		end
		idx = $urandom_range(0, sb.entries - 1);
		base = sb.table_addr[idx];
		if (mode == 2) return base - 1;
		if (mode == 3) return base;
		span = (idx + 1 < sb.entries) ? sb.table_addr[idx + 1] - base : 64'h10000;
		return base + (rand_word() % span);
	endfunction

	initial begin
		int roll;
		sb = new();
		burst_left = 1;
		stall_span = 0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening: empty table, unknown bin, rejected loads, edges.
		send_beat(OP_REPORT, 64'd0, 64'd0);
		send_beat(OP_SAMPLE, 64'd0, 64'h8000_0000_0000_0000);
		send_beat(OP_REPORT, 64'd0, 64'd0);
		send_beat(OP_LOAD, 64'h1000, 64'd0);
		send_beat(OP_LOAD, 64'h1000, 64'd0);
		send_beat(OP_LOAD, 64'h0fff, 64'd0);
		send_beat(OP_LOAD, 64'h2000, 64'd0);
		send_beat(OP_SAMPLE, 64'd0, 64'd0);
		send_beat(OP_SAMPLE, 64'd0, 64'h1000);
		send_beat(OP_SAMPLE, 64'd0, 64'h1fff);
		send_beat(OP_SAMPLE, 64'd0, 64'h2000);
		send_beat(OP_SAMPLE, 64'd0, 64'hffff_ffff_ffff_ffff);
		send_beat(OP_SAMPLE, 64'd0, 64'h0fff);
		send_beat(OP_REPORT, 64'd0, 64'd0);
		send_beat(OP_LOAD, 64'h3000, 64'd0);
		send_beat(OP_SAMPLE, 64'd0, 64'h3001);
		send_beat(OP_REPORT, 64'd0, 64'd0);
		send_beat(OP_START, 64'd0, 64'd0);
		send_beat(OP_REPORT, 64'd0, 64'd0);
		send_beat(OP_LOAD, 64'h0, 64'd0);

		// Random phase: mostly samples against a small growing table.
		for (int n = 0; n < 330; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 2)
				send_beat(OP_START, rand_word(), rand_word());
			else if (roll < 17) begin
				if (sb.entries < 64 && $urandom_range(0, 4) != 0)
					send_beat(OP_LOAD, sb.table_addr[sb.entries - 1] +
						$urandom_range(1, 1 << 20), rand_word());
				else
					send_beat(OP_LOAD, rand_word() % (sb.table_addr[sb.entries - 1] + 1),
						rand_word());
			end else if (roll < 27)
				send_beat(OP_REPORT, rand_word(), rand_word());
			else
				send_beat(OP_SAMPLE, rand_word(), pick_sample_address());
		end
		send_beat(OP_REPORT, 64'd0, 64'd0);

		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
